/* rtl/gfa_pkg.sv */
// Shared constants and widths for the periodic gravity force accumulator.
`timescale 1ns / 1ps
package gfa_pkg;

    localparam int POS_FRAC_BITS_DEF = 24;
    localparam int WORK_FRAC         = 24;
    localparam int POS_W             = 24;
    localparam int MASS_W            = 32;
    localparam int FORCE_W           = 48;
    localparam int AX_W              = 26;   // direction magnitude, Q.24
    localparam int R2_W              = 52;   // squared distance, Q.48
    localparam int ROOT_W            = 27;   // distance, Q.24
    localparam int SQ_W              = 54;   // square root work registers
    localparam int MUL_A_W           = 96;
    localparam int MUL_B_W           = 32;
    localparam int MUL_P_W           = MUL_A_W + MUL_B_W;
    localparam int K_W               = 96;
    localparam int NUM_W             = 128;
    localparam int DEN_W             = 88;
    localparam int Q_W               = FORCE_W + 1;

    localparam logic [31:0] GRAV_RESET = 32'd1;
    localparam logic [23:0] EPS_RESET  = 24'd167772;

    // register index in the configuration space (byte address bit 2)
    localparam logic REG_GRAV = 1'b0;
    localparam logic REG_EPS  = 1'b1;

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_UP    = 2'd1;
    localparam logic [1:0] SIDE_DOWN  = 2'd2;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

endpackage

/* rtl/gfa_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module gfa_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gfa_pkg::MUL_A_W-1:0]   i_a,
    input  logic [gfa_pkg::MUL_B_W-1:0]   i_b,
    output logic                          o_done,
    output logic [gfa_pkg::MUL_P_W-1:0]   o_p
);
    localparam int CNT_W = $clog2(gfa_pkg::MUL_B_W + 1);

    logic [gfa_pkg::MUL_P_W-1:0] r_a;
    logic [gfa_pkg::MUL_B_W-1:0] r_b;
    logic [gfa_pkg::MUL_P_W-1:0] r_p;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_a    <= {{gfa_pkg::MUL_B_W{1'b0}}, i_a};
            r_b    <= i_b;
            r_p    <= '0;
            r_cnt  <= CNT_W'(gfa_pkg::MUL_B_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

/* rtl/gfa_sqrt.sv */
// Digit-by-digit integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module gfa_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gfa_pkg::R2_W-1:0]      i_v,
    output logic                          o_done,
    output logic [gfa_pkg::ROOT_W-1:0]    o_root
);
    localparam int W = gfa_pkg::SQ_W;

    logic [W-1:0] r_v;
    logic [W-1:0] r_res;
    logic [W-1:0] r_bit;
    logic         r_busy;
    logic         r_done;
    logic [W-1:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_v    <= W'(i_v);
            r_res  <= '0;
            r_bit  <= W'(1) << (W - 2);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_v >= w_trial) begin
                r_v   <= r_v - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            if (r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[gfa_pkg::ROOT_W-1:0];
endmodule

/* rtl/gfa_div.sv */
// Restoring divider, one quotient bit per cycle, with an early overflow check.
`timescale 1ns / 1ps
module gfa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gfa_pkg::NUM_W-1:0]     i_num,
    input  logic [gfa_pkg::DEN_W-1:0]     i_den,
    output logic                          o_done,
    output logic                          o_ovf,
    output logic [gfa_pkg::Q_W-1:0]       o_q
);
    localparam int QW    = gfa_pkg::Q_W;
    localparam int DW    = gfa_pkg::DEN_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [QW-1:0]    r_n;
    logic [QW-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_ovf;
    logic [DW-1:0]    w_hi;
    logic [DW:0]      w_t;
    logic             w_ge;

    assign w_hi = DW'(i_num[gfa_pkg::NUM_W-1:QW]);
    assign w_t  = {r_rem, r_n[QW-1]};
    assign w_ge = (w_t >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_den <= i_den;
            r_rem <= w_hi;
            r_n   <= i_num[QW-1:0];
            r_q   <= '0;
            r_cnt <= CNT_W'(QW);
            // quotient would not fit in QW bits
            r_ovf <= (w_hi >= i_den);
            if (w_hi >= i_den) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= DW'(w_t - {1'b0, r_den});
            end else begin
                r_rem <= w_t[DW-1:0];
            end
            r_q   <= {r_q[QW-2:0], w_ge};
            r_n   <= r_n << 1;
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_q    = r_q;
endmodule

/* rtl/grav_force_accumulate_periodic_core.sv */
// Top level: sequencer, configuration registers and force accumulators.
`timescale 1ns / 1ps
// One particle-cell transaction at a time. A transaction with a nonzero cell
// mass and a distance at or above min_distance runs seven 32-step serial
// multiplications (dx^2, dy^2, m1*m2, *G, k*dx, k*dy, r2*r), a 27-step square
// root and two 49-step divisions, plus control states. Zero cell mass skips to
// the accumulate step; a short distance ends after the square root. A finished
// result is held in the output register while the next transaction is taken.
// Writing grav_coefficient or min_distance is allowed only while idle.
module grav_force_accumulate_periodic_core #(
    parameter int POS_FRAC_BITS = gfa_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_first_of_particle,
    input  logic [gfa_pkg::POS_W-1:0]           i_particle_x,
    input  logic [gfa_pkg::POS_W-1:0]           i_particle_y,
    input  logic [gfa_pkg::MASS_W-1:0]          i_particle_mass,
    input  logic [gfa_pkg::POS_W-1:0]           i_center_x,
    input  logic [gfa_pkg::POS_W-1:0]           i_center_y,
    input  logic [gfa_pkg::MASS_W-1:0]          i_cell_mass,
    input  logic [1:0]                          i_vertical_side,
    input  logic [1:0]                          i_horizontal_side,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [gfa_pkg::FORCE_W-1:0]  o_force_x,
    output logic signed [gfa_pkg::FORCE_W-1:0]  o_force_y,
    output logic                                o_contributed,
    output logic                                o_saturated
);
    localparam int DW = POS_FRAC_BITS + 3;
    localparam int SR = (POS_FRAC_BITS > gfa_pkg::WORK_FRAC) ?
                        POS_FRAC_BITS - gfa_pkg::WORK_FRAC : 0;
    localparam int SL = (POS_FRAC_BITS < gfa_pkg::WORK_FRAC) ?
                        gfa_pkg::WORK_FRAC - POS_FRAC_BITS : 0;
    localparam logic [gfa_pkg::POS_W-1:0] PMASK = (POS_FRAC_BITS >= gfa_pkg::POS_W) ?
        {gfa_pkg::POS_W{1'b1}} : gfa_pkg::POS_W'((64'd1 << POS_FRAC_BITS) - 64'd1);
    localparam logic signed [DW-1:0] UNIT = DW'(64'd1 << POS_FRAC_BITS);
    localparam int FW = gfa_pkg::FORCE_W;
    localparam logic signed [FW-1:0] F_MAX = {1'b0, {(FW-1){1'b1}}};
    localparam logic signed [FW-1:0] F_MIN = {1'b1, {(FW-1){1'b0}}};

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_AX2  = 13'b0000000000010,
        S_AY2  = 13'b0000000000100,
        S_SQRT = 13'b0000000001000,
        S_M12  = 13'b0000000010000,
        S_MG   = 13'b0000000100000,
        S_KX   = 13'b0000001000000,
        S_KY   = 13'b0000010000000,
        S_DEN  = 13'b0000100000000,
        S_DIVX = 13'b0001000000000,
        S_DIVY = 13'b0010000000000,
        S_ACC  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [31:0]                   r_grav;
    logic [23:0]                   r_eps;

    // transaction registers
    logic                          r_first;
    logic [gfa_pkg::AX_W-1:0]      r_ax, r_ay;
    logic                          r_negx, r_negy;
    logic [gfa_pkg::MASS_W-1:0]    r_m1, r_m2;
    logic [gfa_pkg::R2_W-1:0]      r_r2;
    logic [gfa_pkg::ROOT_W-1:0]    r_root;
    logic [gfa_pkg::K_W-1:0]       r_k;
    logic [gfa_pkg::NUM_W-1:0]     r_numx, r_numy;
    logic [gfa_pkg::DEN_W-1:0]     r_den;
    logic signed [FW-1:0]          r_fx, r_fy;
    logic                          r_sat;
    logic                          r_issued;

    // accumulators and output register
    logic signed [FW-1:0]          r_accx, r_accy;
    logic                          r_ovalid;
    logic signed [FW-1:0]          r_ofx, r_ofy;
    logic                          r_ocontrib, r_osat;

    // direction
    logic signed [DW-1:0]          w_dx, w_dy;
    logic [DW-1:0]                 w_magx, w_magy;
    logic [DW+7:0]                 w_wx, w_wy;

    // units
    logic                          w_mul_start, w_sqrt_start, w_div_start;
    logic                          w_mul_done, w_sqrt_done, w_div_done;
    logic [gfa_pkg::MUL_A_W-1:0]   w_mul_a;
    logic [gfa_pkg::MUL_B_W-1:0]   w_mul_b;
    logic [gfa_pkg::MUL_P_W-1:0]   w_mul_p;
    logic [gfa_pkg::ROOT_W-1:0]    w_root;
    logic [gfa_pkg::NUM_W-1:0]     w_div_num;
    logic                          w_div_ovf;
    logic [gfa_pkg::Q_W-1:0]       w_div_q;

    // clip and accumulate
    logic                          w_neg;
    logic [FW-1:0]                 w_lim;
    logic                          w_big;
    logic [FW-1:0]                 w_mag;
    logic signed [FW-1:0]          w_clip;
    logic signed [FW:0]            w_sumx, w_sumy;
    logic signed [FW-1:0]          w_basex, w_basey;
    logic signed [FW-1:0]          w_accx, w_accy;
    logic                          w_satx, w_saty;
    logic                          w_accept, w_emit, w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        case (paddr[2])
            gfa_pkg::REG_GRAV: prdata = r_grav;
            gfa_pkg::REG_EPS:  prdata = {8'd0, r_eps};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= gfa_pkg::GRAV_RESET;
            r_eps  <= gfa_pkg::EPS_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                gfa_pkg::REG_GRAV: r_grav <= pwdata;
                gfa_pkg::REG_EPS:  r_eps  <= pwdata[23:0];
                default:           r_grav <= r_grav;
            endcase
        end
    end

    // direction vector to the shifted periodic image, magnitude in Q.24
    always_comb begin
        w_dx = $signed(DW'(i_center_x & PMASK)) - $signed(DW'(i_particle_x & PMASK));
        w_dy = $signed(DW'(i_center_y & PMASK)) - $signed(DW'(i_particle_y & PMASK));
        case (i_horizontal_side)
            gfa_pkg::SIDE_LEFT:  w_dx = w_dx - UNIT;
            gfa_pkg::SIDE_RIGHT: w_dx = w_dx + UNIT;
            default:             w_dx = w_dx;
        endcase
        case (i_vertical_side)
            gfa_pkg::SIDE_UP:   w_dy = w_dy + UNIT;
            gfa_pkg::SIDE_DOWN: w_dy = w_dy - UNIT;
            default:            w_dy = w_dy;
        endcase
        w_magx = w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
        w_magy = w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
        w_wx   = ((DW+8)'(w_magx) >> SR) << SL;
        w_wy   = ((DW+8)'(w_magy) >> SR) << SL;
    end

    // multiplier operands follow the step
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_AX2: begin
                w_mul_a = gfa_pkg::MUL_A_W'(r_ax);
                w_mul_b = gfa_pkg::MUL_B_W'(r_ax);
            end
            S_AY2: begin
                w_mul_a = gfa_pkg::MUL_A_W'(r_ay);
                w_mul_b = gfa_pkg::MUL_B_W'(r_ay);
            end
            S_M12: begin
                w_mul_a = gfa_pkg::MUL_A_W'(r_m1);
                w_mul_b = r_m2;
            end
            S_MG: begin
                w_mul_a = r_k;
                w_mul_b = r_grav;
            end
            S_KX: begin
                w_mul_a = r_k;
                w_mul_b = gfa_pkg::MUL_B_W'(r_ax);
            end
            S_KY: begin
                w_mul_a = r_k;
                w_mul_b = gfa_pkg::MUL_B_W'(r_ay);
            end
            S_DEN: begin
                w_mul_a = gfa_pkg::MUL_A_W'(r_r2);
                w_mul_b = gfa_pkg::MUL_B_W'(r_root);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_start  = !r_issued && (r_state == S_AX2 || r_state == S_AY2 ||
                          r_state == S_M12 || r_state == S_MG || r_state == S_KX ||
                          r_state == S_KY || r_state == S_DEN);
    assign w_sqrt_start = !r_issued && (r_state == S_SQRT);
    assign w_div_start  = !r_issued && (r_state == S_DIVX || r_state == S_DIVY);
    assign w_div_num    = (r_state == S_DIVY) ? r_numy : r_numx;

    gfa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    gfa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_v     (r_r2),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    gfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_ovf   (w_div_ovf),
        .o_q     (w_div_q)
    );

    // clip one quotient to the signed force range
    always_comb begin
        w_neg  = (r_state == S_DIVY) ? r_negy : r_negx;
        w_lim  = w_neg ? FW'(F_MIN) : FW'(F_MAX);
        w_big  = w_div_ovf || (w_div_q > {1'b0, w_lim});
        w_mag  = w_big ? w_lim : w_div_q[FW-1:0];
        w_clip = w_neg ? $signed(-w_mag) : $signed(w_mag);
    end

    // saturating accumulate
    always_comb begin
        w_basex = r_first ? '0 : r_accx;
        w_basey = r_first ? '0 : r_accy;
        w_sumx  = {w_basex[FW-1], w_basex} + {r_fx[FW-1], r_fx};
        w_sumy  = {w_basey[FW-1], w_basey} + {r_fy[FW-1], r_fy};
        w_satx  = (w_sumx[FW] != w_sumx[FW-1]);
        w_saty  = (w_sumy[FW] != w_sumy[FW-1]);
        w_accx  = w_satx ? (w_sumx[FW] ? F_MIN : F_MAX) : w_sumx[FW-1:0];
        w_accy  = w_saty ? (w_sumy[FW] ? F_MIN : F_MAX) : w_sumy[FW-1:0];
    end

    assign w_emit = (r_state == S_ACC) && (!r_ovalid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) begin
                n_state = (i_cell_mass == '0) ? S_ACC : S_AX2;
            end
            S_AX2:  if (w_mul_done) n_state = S_AY2;
            S_AY2:  if (w_mul_done) n_state = S_SQRT;
            S_SQRT: if (w_sqrt_done) begin
                n_state = (w_root == '0 || w_root < gfa_pkg::ROOT_W'(r_eps)) ?
                          S_ACC : S_M12;
            end
            S_M12:  if (w_mul_done) n_state = S_MG;
            S_MG:   if (w_mul_done) n_state = S_KX;
            S_KX:   if (w_mul_done) n_state = S_KY;
            S_KY:   if (w_mul_done) n_state = S_DEN;
            S_DEN:  if (w_mul_done) n_state = S_DIVX;
            S_DIVX: if (w_div_done) n_state = S_DIVY;
            S_DIVY: if (w_div_done) n_state = S_ACC;
            S_ACC:  if (w_emit) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
            r_accx   <= '0;
            r_accy   <= '0;
        end else begin
            r_state <= n_state;
            if (w_mul_start || w_sqrt_start || w_div_start) begin
                r_issued <= 1'b1;
            end else if (w_mul_done || w_sqrt_done || w_div_done) begin
                r_issued <= 1'b0;
            end
            if (w_emit) begin
                r_accx   <= w_accx;
                r_accy   <= w_accy;
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first <= i_first_of_particle;
            r_ax    <= w_wx[gfa_pkg::AX_W-1:0];
            r_ay    <= w_wy[gfa_pkg::AX_W-1:0];
            r_negx  <= w_dx[DW-1];
            r_negy  <= w_dy[DW-1];
            r_m1    <= i_particle_mass;
            r_m2    <= i_cell_mass;
            r_fx    <= '0;
            r_fy    <= '0;
            r_sat   <= 1'b0;
        end
        if (w_mul_done) begin
            case (r_state)
                S_AX2: r_r2   <= w_mul_p[gfa_pkg::R2_W-1:0];
                S_AY2: r_r2   <= r_r2 + w_mul_p[gfa_pkg::R2_W-1:0];
                S_M12: r_k    <= gfa_pkg::K_W'(w_mul_p[2*gfa_pkg::MASS_W-1:0]);
                S_MG:  r_k    <= w_mul_p[gfa_pkg::K_W-1:0];
                S_KX:  r_numx <= w_mul_p;
                S_KY:  r_numy <= w_mul_p;
                S_DEN: r_den  <= {w_mul_p[gfa_pkg::DEN_W-9:0], 8'd0};
                default: r_k  <= r_k;
            endcase
        end
        if (w_sqrt_done) begin
            r_root <= w_root;
        end
        if (w_div_done) begin
            if (r_state == S_DIVY) begin
                r_fy <= w_clip;
            end else begin
                r_fx <= w_clip;
            end
            r_sat <= r_sat | w_big;
        end
        if (w_emit) begin
            r_ofx      <= w_accx;
            r_ofy      <= w_accy;
            r_ocontrib <= (r_fx != '0) || (r_fy != '0);
            r_osat     <= r_sat || w_satx || w_saty;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_force_x     = r_ofx;
    assign o_force_y     = r_ofy;
    assign o_contributed = r_ocontrib;
    assign o_saturated   = r_osat;
endmodule

/* rtl/gfa_chk.sv */
// Port-level checks for the gravity force accumulator, bound to the top level.
`timescale 1ns / 1ps
module gfa_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [gfa_pkg::FORCE_W-1:0]  o_force_x,
    input logic signed [gfa_pkg::FORCE_W-1:0]  o_force_y
);
    // a stalled result stays up
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_force_x) && $stable(o_force_y))
        else $error("stalled result changed");

    // one transaction in flight: input closes right after a transaction
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second transaction taken while busy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("reset did not return to idle");
endmodule

bind grav_force_accumulate_periodic_core gfa_chk u_gfa_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_force_x (o_force_x),
    .o_force_y (o_force_y)
);
